// File: hdl/bmp24_pkg.sv
// Shared types and constants of the 24-bit BMP stream encoder.
package bmp24_pkg;

    localparam int DIM_W  = 13;
    localparam int CMP_W  = DIM_W + 1;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int REG_IDX_W = 1;
    localparam int WORD_W = 32;
    localparam int PROD_W = 28;
    localparam int ROWB_W = 15;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [POS_W-1:0] POS_SIG_B = 6'd0;
    localparam logic [POS_W-1:0] POS_SIG_M = 6'd1;
    localparam logic [POS_W-1:0] POS_FIRST_WORD = 6'd2;
    localparam logic [POS_W-1:0] HDR_LEN   = 6'd54;
    localparam logic [POS_W-1:0] POS_BLUE  = 6'd54;
    localparam logic [POS_W-1:0] POS_GREEN = 6'd55;
    localparam logic [POS_W-1:0] POS_RED   = 6'd56;

    localparam logic [BYTE_W-1:0] SIG_B = 8'h42;
    localparam logic [BYTE_W-1:0] SIG_M = 8'h4D;

    localparam logic [WORD_W-1:0] DATA_OFFSET = 32'd54;
    localparam logic [WORD_W-1:0] INFO_SIZE   = 32'd40;
    localparam logic [WORD_W-1:0] PLANES_BPP  = 32'h0018_0001;
    localparam logic [WORD_W-1:0] PELS_PER_M  = 32'd2835;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

endpackage

// File: hdl/bmp24_if.sv
// Valid/ready channel interfaces for pixels in and file bytes out.
interface bmp24_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface bmp24_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       last_of_run;
    logic       end_of_file;

    modport source (output valid, output file_byte, output last_of_run, output end_of_file,
                    input ready);
    modport sink (input valid, input file_byte, input last_of_run, input end_of_file,
                  output ready);
endinterface

// File: hdl/bmp24_header.sv
// Header byte generator: size computation and the 54-byte header layout.
module bmp24_header
(
    input  logic                             clk,
    input  bmp24_pkg::dims_t                 dims,
    input  logic [bmp24_pkg::POS_W-1:0]      pos,
    output logic [bmp24_pkg::BYTE_W-1:0]     hdr_byte
);

    logic [bmp24_pkg::ROWB_W-1:0] row_sum;
    logic [bmp24_pkg::ROWB_W-1:0] row_bytes;
    logic [bmp24_pkg::PROD_W-1:0] prod;
    logic [bmp24_pkg::WORD_W-1:0] image_bytes_reg;
    logic [bmp24_pkg::WORD_W-1:0] file_size;
    logic [bmp24_pkg::POS_W-1:0]  word_pos;
    logic [3:0]                   word_idx;
    logic [1:0]                   byte_idx;
    logic [bmp24_pkg::WORD_W-1:0] word;

    // Rows are padded up to a multiple of four bytes.
    assign row_sum   = bmp24_pkg::ROWB_W'(dims.width) * 15'd3 + 15'd3;
    assign row_bytes = {row_sum[bmp24_pkg::ROWB_W-1:2], 2'b00};
    assign prod      = bmp24_pkg::PROD_W'(row_bytes) * bmp24_pkg::PROD_W'(dims.height);

    always_ff @(posedge clk)
    begin
        image_bytes_reg <= bmp24_pkg::WORD_W'(prod);
    end

    assign file_size = image_bytes_reg + bmp24_pkg::DATA_OFFSET;
    assign word_pos  = pos - bmp24_pkg::POS_FIRST_WORD;
    assign word_idx  = word_pos[5:2];
    assign byte_idx  = word_pos[1:0];

    always_comb
    begin
        case (word_idx)
            4'd0:    word = file_size;
            4'd2:    word = bmp24_pkg::DATA_OFFSET;
            4'd3:    word = bmp24_pkg::INFO_SIZE;
            4'd4:    word = bmp24_pkg::WORD_W'(dims.width);
            4'd5:    word = bmp24_pkg::WORD_W'(dims.height);
            4'd6:    word = bmp24_pkg::PLANES_BPP;
            4'd8:    word = image_bytes_reg;
            4'd9:    word = bmp24_pkg::PELS_PER_M;
            4'd10:   word = bmp24_pkg::PELS_PER_M;
            default: word = '0;
        endcase
    end

    always_comb
    begin
        if (pos == bmp24_pkg::POS_SIG_B)
        begin
            hdr_byte = bmp24_pkg::SIG_B;
        end
        else if (pos == bmp24_pkg::POS_SIG_M)
        begin
            hdr_byte = bmp24_pkg::SIG_M;
        end
        else
        begin
            hdr_byte = word[{byte_idx, 3'b000} +: 8];
        end
    end

endmodule

// File: hdl/bmp24_stream_encoder.sv
// Top level of the 24-bit BMP stream encoder.
//
//  Channel   Direction  Payload                                 Moves
//  pixels    in         red, green, blue                        one pixel per request
//  stream    out        file_byte, last_of_run, end_of_file     one file byte per request
//  cfg       in         cfg_index, cfg_data                     write when cfg_we is high
//
// A pixel goes out as its blue, green and red bytes, plus the 54-byte header
// before the first pixel of a frame and 0 to 3 bytes of row padding after the last
// pixel of a row; all pass through the single byte-wide output register.
// Reset gives a 1 x 1 frame with the header pending and empties both registers.
// A new pixel is taken in the cycle in which the previous pixel's last byte moves
// into the output register, while that byte still waits for the downstream side.
module bmp24_stream_encoder
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bmp24_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [bmp24_pkg::DIM_W-1:0]          cfg_data,
    bmp24_pix_if.sink                            pixels,
    bmp24_byte_if.source                         stream
);

    localparam int DIM_MAX_VAL = (1 << bmp24_pkg::DIM_W) - 1;
    localparam int DIM_CAP = (MAX_DIM < DIM_MAX_VAL) ? MAX_DIM : DIM_MAX_VAL;
    localparam int CNT_W = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;

    logic [bmp24_pkg::DIM_W-1:0]  width_reg;
    logic [bmp24_pkg::DIM_W-1:0]  height_reg;
    bmp24_pkg::dims_t             dims;

    logic                         pix_valid_reg;
    logic [7:0]                   red_reg;
    logic [7:0]                   green_reg;
    logic [7:0]                   blue_reg;
    logic [bmp24_pkg::POS_W-1:0]  pos_reg;
    logic [bmp24_pkg::POS_W-1:0]  pos_next;
    logic [CNT_W-1:0]             col_reg;
    logic [CNT_W-1:0]             col_next;
    logic [CNT_W-1:0]             row_reg;
    logic [CNT_W-1:0]             row_next;
    logic                         hdr_pending_reg;
    logic                         hdr_pending_next;

    logic                         out_valid_reg;
    logic [7:0]                   out_byte_reg;
    logic                         out_last_reg;
    logic                         out_eof_reg;

    logic                         row_end;
    logic                         frame_end;
    logic [bmp24_pkg::POS_W-1:0]  last_pos;
    logic                         emit;
    logic                         is_last;
    logic                         done;
    logic                         accept;
    logic [7:0]                   hdr_byte;
    logic [7:0]                   cur_byte;

    function automatic logic [bmp24_pkg::DIM_W-1:0] clamp_dim(
        input logic [bmp24_pkg::DIM_W-1:0] v);
        logic [bmp24_pkg::DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = bmp24_pkg::DIM_W'(1);
            end
            else if (v > bmp24_pkg::DIM_W'(DIM_CAP))
            begin
                r = bmp24_pkg::DIM_W'(DIM_CAP);
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bmp24_pkg::DIM_W'(1);
            height_reg <= bmp24_pkg::DIM_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmp24_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bmp24_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dims.width  = clamp_dim(width_reg);
    assign dims.height = clamp_dim(height_reg);

    bmp24_header u_header
    (
        .clk      (clk),
        .dims     (dims),
        .pos      (pos_reg),
        .hdr_byte (hdr_byte)
    );

    // A row ends when the next column reaches or passes the width; the same holds
    // for rows against the height, so a shrunk frame never lets a counter run away.
    assign row_end   = (bmp24_pkg::CMP_W'(col_reg) + 14'd1) >= bmp24_pkg::CMP_W'(dims.width);
    assign frame_end = row_end &&
                       ((bmp24_pkg::CMP_W'(row_reg) + 14'd1) >= bmp24_pkg::CMP_W'(dims.height));
    assign last_pos  = bmp24_pkg::POS_RED +
                       (row_end ? bmp24_pkg::POS_W'(dims.width[1:0]) : '0);

    assign emit    = pix_valid_reg && (!out_valid_reg || stream.ready);
    assign is_last = (pos_reg == last_pos);
    assign done    = emit && is_last;
    assign pixels.ready = !pix_valid_reg || done;
    assign accept  = pixels.valid && pixels.ready;

    always_comb
    begin
        if (pos_reg < bmp24_pkg::HDR_LEN)
        begin
            cur_byte = hdr_byte;
        end
        else
        begin
            case (pos_reg)
                bmp24_pkg::POS_BLUE:  cur_byte = blue_reg;
                bmp24_pkg::POS_GREEN: cur_byte = green_reg;
                bmp24_pkg::POS_RED:   cur_byte = red_reg;
                default:              cur_byte = '0;
            endcase
        end
    end

    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        hdr_pending_next = hdr_pending_reg;
        if (done)
        begin
            hdr_pending_next = frame_end;
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = hdr_pending_next ? bmp24_pkg::POS_SIG_B : bmp24_pkg::POS_BLUE;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg   <= 1'b0;
            pos_reg         <= bmp24_pkg::POS_SIG_B;
            col_reg         <= '0;
            row_reg         <= '0;
            hdr_pending_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            hdr_pending_reg <= hdr_pending_next;
            if (accept)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (done)
            begin
                pix_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg   <= pixels.red;
            green_reg <= pixels.green;
            blue_reg  <= pixels.blue;
        end
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
            out_eof_reg  <= is_last && frame_end;
        end
    end

    assign stream.valid       = out_valid_reg;
    assign stream.file_byte   = out_byte_reg;
    assign stream.last_of_run = out_last_reg;
    assign stream.end_of_file = out_eof_reg;

endmodule

// File: hdl/bmp24_checker.sv
// Port-level checker of the BMP stream encoder and its bind to the top level.
module bmp24_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] file_byte,
    input logic       last_of_run,
    input logic       end_of_file
);

    logic       pix_acc;
    logic       out_acc;
    logic       run_end;
    logic [1:0] open_reg;
    logic       file_start_reg;

    assign pix_acc = pix_valid && pix_ready;
    assign out_acc = out_valid && out_ready;
    assign run_end = out_acc && last_of_run;

    // Pixels taken in whose last byte has not yet been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg       <= 2'd0;
            file_start_reg <= 1'b1;
        end
        else
        begin
            open_reg <= open_reg + {1'b0, pix_acc} - {1'b0, run_end};
            if (out_acc)
            begin
                file_start_reg <= end_of_file;
            end
        end
    end

    a_eof_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_file |-> last_of_run)
        else $error("end of file without end of run");

    a_file_starts_with_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && file_start_reg |-> file_byte == 8'h42)
        else $error("file does not start with the signature");

    a_no_phantom_run: assert property (@(posedge clk) disable iff (!rst_n)
        run_end |-> open_reg != 2'd0)
        else $error("end of run without an open pixel");

    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == 2'd2 |-> !pix_ready)
        else $error("pixel taken with two pixels still open");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(file_byte))
        else $error("stalled output byte changed");

endmodule

bind bmp24_stream_encoder bmp24_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_valid   (pixels.valid),
    .pix_ready   (pixels.ready),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .file_byte   (stream.file_byte),
    .last_of_run (stream.last_of_run),
    .end_of_file (stream.end_of_file)
);
